/* design/nes_pkg.sv */
// Shared types, widths and constants of the normalized edge-aware smoother.
// Used by the interfaces, the register file, the controller and the datapath.
package nes_pkg;

  // kernel geometry
  localparam int MAX_HALF_WIDTH = 3;
  localparam int TAPS           = 2 * MAX_HALF_WIDTH + 1;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int HW_W     = 2;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  // each product stays within 2^30 in magnitude, so TAPS of them fit here
  localparam int ACC_W    = PROD_W - 1 + $clog2(TAPS);
  localparam int SCALE_W  = WEIGHT_W + $clog2(TAPS);
  localparam int QUO_W    = SAMPLE_W;
  localparam int BIT_W    = $clog2(QUO_W);
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int TAP_W    = $clog2(TAPS);

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // result limits
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // register reset values: unit weight (1.0 in Q4.12) on the three middle taps
  localparam logic [HW_W-1:0]     HW_RESET    = 2'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_UNIT = 16'd4096;

  // register indexes, byte address divided by four
  typedef enum logic [2:0] {
    REG_HALF_WIDTH,
    REG_W_M3,
    REG_W_M2,
    REG_W_M1,
    REG_W_C,
    REG_W_P1,
    REG_W_P2,
    REG_W_P3
  } reg_idx_t;

  typedef logic [TAPS-1:0][WEIGHT_W-1:0] weight_vec_t;

  // live configuration seen by the datapath; weight[0] is the leftmost tap
  typedef struct packed {
    logic [HW_W-1:0] half_width;
    weight_vec_t     weight;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mac_start;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic emit;
    logic next_c;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pending;
    logic tap_last;
    logic div_last;
    logic out_free;
    logic more;
    logic last;
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_MAC,
    S_DRAIN,
    S_DINIT,
    S_DIV,
    S_EMIT
  } state_t;

  // reset kernel: unit weight on the centre and its two direct neighbours
  function automatic weight_vec_t weight_reset();
    weight_vec_t v;
    for (int i = 0; i < TAPS; i++) begin
      if (i >= MAX_HALF_WIDTH - 1 && i <= MAX_HALF_WIDTH + 1) begin
        v[i] = WEIGHT_UNIT;
      end else begin
        v[i] = '0;
      end
    end
    return v;
  endfunction

endpackage

/* design/nes_if.sv */
// Valid/ready channels of the smoother: trace samples in, smoothed words out.
// Payload widths come from nes_pkg.
interface nes_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nes_pkg::SAMPLE_W-1:0]   sample;
  logic                                  trace_end;

  modport source(output valid, sample, trace_end, input ready);
  modport sink(input valid, sample, trace_end, output ready);
endinterface

interface nes_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nes_pkg::SAMPLE_W-1:0]   smoothed;
  logic                                  zero_weight;
  logic                                  trace_done;

  modport source(output valid, smoothed, zero_weight, trace_done, input ready);
  modport sink(input valid, smoothed, zero_weight, trace_done, output ready);
endinterface

/* design/normalized_edge_aware_smoother_top.sv */
// Normalized edge-aware smoother: each word in is one trace sample, each word out the
// renormalized kernel average of a sample, released once its right-hand neighbours
// arrive; a sample marked trace_end flushes the pending results, oldest first. Every
// result passes one multiplier shared over the taps, then a 16-step restoring divider,
// before it is loaded into the output; each extra result of a flush repeats both, and a
// sample that releases nothing only passes the planning step. Input is taken only
// between results, in the cycle after the last result of a sample at the earliest,
// while a finished word may still wait at the output; a new sample is thus not taken
// before all results of the previous one are loaded.
// Registers lie at byte address 4*index: half width, then weights -3 to +3 in Q4.12.
module normalized_edge_aware_smoother_top (
  input  logic                       clk,
  input  logic                       rst_n,
  nes_in_if.sink                     in_if,
  nes_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nes_pkg::CFG_AW-1:0] paddr,
  input  logic [nes_pkg::CFG_DW-1:0] pwdata,
  output logic [nes_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  nes_pkg::cfg_t cfg;
  nes_pkg::cmd_t cmd;
  nes_pkg::sts_t sts;

  nes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nes_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_if.sample),
    .in_trace_end    (in_if.trace_end),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_smoothed    (out_if.smoothed),
    .out_zero_weight (out_if.zero_weight),
    .out_trace_done  (out_if.trace_done)
  );

endmodule

/* design/nes_cfg.sv */
// APB-style register file: half width and the seven Q4.12 kernel weights.
// Depends on nes_pkg for the register map and reset values.
module nes_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nes_pkg::CFG_AW-1:0] paddr,
  input  logic [nes_pkg::CFG_DW-1:0] pwdata,
  output logic [nes_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output nes_pkg::cfg_t              cfg
);

  logic [nes_pkg::HW_W-1:0] hw_r;
  nes_pkg::weight_vec_t     weight_r;
  nes_pkg::reg_idx_t        idx;
  logic                     wr_en;

  assign idx    = nes_pkg::reg_idx_t'(paddr[nes_pkg::CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r     <= nes_pkg::HW_RESET;
      weight_r <= nes_pkg::weight_reset();
    end else if (wr_en) begin
      unique case (idx)
        nes_pkg::REG_HALF_WIDTH: hw_r <= pwdata[nes_pkg::HW_W-1:0];
        default: weight_r[idx - nes_pkg::REG_W_M3] <= pwdata[nes_pkg::WEIGHT_W-1:0];
      endcase
    end
  end

  // read back; weights come back sign extended
  always_comb begin
    unique case (idx)
      nes_pkg::REG_HALF_WIDTH: prdata = nes_pkg::CFG_DW'(hw_r);
      default: prdata = nes_pkg::CFG_DW'($signed(weight_r[idx - nes_pkg::REG_W_M3]));
    endcase
  end

  // cap the half width at the kernel size
  assign cfg.half_width = (hw_r > nes_pkg::HW_W'(nes_pkg::MAX_HALF_WIDTH))
                        ? nes_pkg::HW_W'(nes_pkg::MAX_HALF_WIDTH) : hw_r;
  assign cfg.weight     = weight_r;

endmodule

/* design/nes_ctrl.sv */
// Sequencer of the smoother: accept a word, then per result run the
// multiply-accumulate, the divider and the output load. Depends on nes_pkg.
module nes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nes_pkg::sts_t     sts,
  output nes_pkg::cmd_t     cmd
);

  nes_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nes_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nes_pkg::S_IDLE: begin
        if (in_valid) state_nxt = nes_pkg::S_PLAN;
      end
      nes_pkg::S_PLAN: begin
        state_nxt = sts.pending ? nes_pkg::S_MAC : nes_pkg::S_IDLE;
      end
      nes_pkg::S_MAC: begin
        if (sts.tap_last) state_nxt = nes_pkg::S_DRAIN;
      end
      nes_pkg::S_DRAIN: state_nxt = nes_pkg::S_DINIT;
      nes_pkg::S_DINIT: state_nxt = nes_pkg::S_DIV;
      nes_pkg::S_DIV: begin
        if (sts.div_last) state_nxt = nes_pkg::S_EMIT;
      end
      nes_pkg::S_EMIT: begin
        if (sts.out_free) state_nxt = sts.more ? nes_pkg::S_MAC : nes_pkg::S_IDLE;
      end
      default: state_nxt = nes_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      nes_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      nes_pkg::S_PLAN:  cmd.mac_start = sts.pending;
      nes_pkg::S_MAC:   cmd.mac_step  = 1'b1;
      nes_pkg::S_DRAIN: ;
      nes_pkg::S_DINIT: cmd.div_start = 1'b1;
      nes_pkg::S_DIV:   cmd.div_step  = 1'b1;
      nes_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.next_c    = sts.more;
          cmd.mac_start = sts.more;
          cmd.clear     = !sts.more && sts.last;
        end
      end
      default: ;
    endcase
  end

  // a word taken always leads to the planning step
  a_load_plan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == nes_pkg::S_PLAN)
    else $error("accepted word did not move to planning");

  // the divider runs out only into the output step
  a_div_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nes_pkg::S_DIV && sts.div_last) |=> state_r == nes_pkg::S_EMIT)
    else $error("divider finished without output step");

endmodule

/* design/nes_datapath.sv */
// Datapath of the smoother: sample window, one shared multiplier with its
// accumulators, a 16-step restoring divider and the output register. Uses nes_pkg.
module nes_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nes_pkg::cfg_t                       cfg,
  input  nes_pkg::cmd_t                       cmd,
  output nes_pkg::sts_t                       sts,
  input  logic signed [nes_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_trace_end,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [nes_pkg::SAMPLE_W-1:0] out_smoothed,
  output logic                                out_zero_weight,
  output logic                                out_trace_done
);

  localparam int CNT_W = nes_pkg::CNT_W;
  localparam int TAP_W = nes_pkg::TAP_W;
  localparam int HW_W  = nes_pkg::HW_W;
  localparam int IDX_W = CNT_W + 2;
  localparam int ACC_W = nes_pkg::ACC_W;
  localparam int SCL_W = nes_pkg::SCALE_W;
  localparam int QUO_W = nes_pkg::QUO_W;
  localparam int SAT_W = SCL_W + QUO_W;

  // window, newest at index 0; entries past the count are never read
  logic signed [nes_pkg::SAMPLE_W-1:0] win_r [nes_pkg::TAPS];
  logic [CNT_W-1:0]                    cnt_r;
  logic                                last_r;
  logic [HW_W-1:0]                     c_r;
  logic [TAP_W-1:0]                    tap_r;

  logic signed [nes_pkg::PROD_W-1:0]   prod_r;
  logic signed [nes_pkg::WEIGHT_W-1:0] wsel_r;
  logic                                prod_vld_r;
  logic signed [ACC_W-1:0]             acc_r;
  logic signed [SCL_W-1:0]             scale_r;

  logic [ACC_W-1:0]                    rem_r;
  logic [ACC_W-1:0]                    dsr_r;
  logic [QUO_W-1:0]                    quo_r;
  logic [nes_pkg::BIT_W-1:0]           bit_r;
  logic                                neg_r;
  logic                                sat_r;
  logic                                zero_r;

  logic                                out_valid_r;
  logic signed [nes_pkg::SAMPLE_W-1:0] smoothed_r;
  logic                                zero_out_r;
  logic                                done_out_r;

  logic [HW_W-1:0]                     hw;
  logic [CNT_W-1:0]                    n_new;
  logic [CNT_W-1:0]                    n_m1;
  logic [HW_W-1:0]                     c_load;
  logic signed [IDX_W-1:0]             idx_s;
  logic                                tap_ok;
  logic [TAP_W-1:0]                    idx;
  logic [TAP_W-1:0]                    widx;
  logic signed [nes_pkg::SAMPLE_W-1:0] samp;
  logic signed [nes_pkg::WEIGHT_W-1:0] wgt;
  logic signed [nes_pkg::PROD_W-1:0]   prod_c;
  logic [ACC_W-1:0]                    acc_abs;
  logic [SCL_W-1:0]                    scale_abs;
  logic                                sat_c;
  logic                                ge;
  logic signed [nes_pkg::SAMPLE_W-1:0] result;

  assign hw = cfg.half_width;

  // count after this word and the first centre to emit
  always_comb begin
    n_new  = (cnt_r < CNT_W'(nes_pkg::TAPS)) ? cnt_r + 1'b1 : cnt_r;
    n_m1   = n_new - 1'b1;
    c_load = hw;
    if (in_trace_end && n_m1 < CNT_W'(hw)) c_load = n_m1[HW_W-1:0];
  end

  // shift in a word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r[0] <= in_sample;
      for (int i = 1; i < nes_pkg::TAPS; i++) win_r[i] <= win_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= 1'b0;
      c_r    <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r  <= n_new;
        last_r <= in_trace_end;
        c_r    <= c_load;
      end else begin
        if (cmd.clear)  cnt_r <= '0;
        if (cmd.next_c) c_r   <= c_r - 1'b1;
      end
    end
  end

  // tap select: window index is c + hw - d, valid when inside the trace
  always_comb begin
    idx_s  = $signed(IDX_W'(c_r)) + $signed(IDX_W'(hw)) - $signed(IDX_W'(tap_r));
    tap_ok = !idx_s[IDX_W-1] && (idx_s[IDX_W-2:0] < (IDX_W-1)'(cnt_r));
    idx    = idx_s[TAP_W-1:0];
    widx   = tap_r + TAP_W'(nes_pkg::MAX_HALF_WIDTH) - TAP_W'(hw);
    samp   = tap_ok ? win_r[idx] : '0;
    wgt    = tap_ok ? $signed(cfg.weight[widx]) : '0;
    prod_c = wgt * samp;
  end

  // tap counter and product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r      <= '0;
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mac_step;
      if (cmd.mac_start)     tap_r <= '0;
      else if (cmd.mac_step) tap_r <= tap_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_step) begin
      prod_r <= prod_c;
      wsel_r <= wgt;
    end
  end

  // accumulate weighted sum and weight sum one stage behind the multiplier
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      acc_r   <= '0;
      scale_r <= '0;
    end else if (prod_vld_r) begin
      acc_r   <= acc_r + ACC_W'(prod_r);
      scale_r <= scale_r + SCL_W'(wsel_r);
    end
  end

  // divider setup: magnitudes, sign and early saturation
  always_comb begin
    acc_abs   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    scale_abs = scale_r[SCL_W-1] ? SCL_W'(-scale_r) : SCL_W'(scale_r);
    sat_c     = SAT_W'(acc_abs) >= SAT_W'({scale_abs, {QUO_W{1'b0}}});
    ge        = rem_r >= dsr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.div_start) begin
      bit_r <= nes_pkg::BIT_W'(QUO_W - 1);
    end else if (cmd.div_step) begin
      bit_r <= bit_r - 1'b1;
    end
  end

  // restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= acc_abs;
      dsr_r  <= ACC_W'({scale_abs, {(QUO_W-1){1'b0}}});
      quo_r  <= '0;
      neg_r  <= acc_r[ACC_W-1] ^ scale_r[SCL_W-1];
      sat_r  <= sat_c;
      zero_r <= (scale_r == '0);
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dsr_r;
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  // sign and saturate the quotient
  always_comb begin
    priority if (zero_r) begin
      result = '0;
    end else if (sat_r) begin
      result = neg_r ? nes_pkg::SMP_MIN : nes_pkg::SMP_MAX;
    end else if (!neg_r) begin
      result = quo_r[QUO_W-1] ? nes_pkg::SMP_MAX : $signed(quo_r);
    end else begin
      result = (quo_r > QUO_W'(nes_pkg::SMP_MIN)) ? nes_pkg::SMP_MIN
             : $signed(~quo_r + 1'b1);
    end
  end

  // output register; hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smoothed_r <= result;
      zero_out_r <= zero_r;
      done_out_r <= last_r && (c_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_smoothed    = smoothed_r;
  assign out_zero_weight = zero_out_r;
  assign out_trace_done  = done_out_r;

  // status to the controller
  assign sts.pending  = last_r || (cnt_r > CNT_W'(hw));
  assign sts.tap_last = (tap_r == TAP_W'({hw, 1'b0}));
  assign sts.div_last = (bit_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.more     = last_r && (c_r != '0);
  assign sts.last     = last_r;

  // never overwrite a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("output word overwritten");

  // trace end leaves an empty window count
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> cnt_r == '0)
    else $error("count not cleared at trace end");

  // a loaded result shows up as valid
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted word not valid");

endmodule
